// ----- rtl/rfts_pkg.sv -----
// ----------------------------------------------------------------------------
// rfts_pkg
// Shared types, codes and helpers of the range flow table switch.
// ----------------------------------------------------------------------------
`default_nettype none

package rfts_pkg;

    // default number of rule cells in the chain
    localparam int unsigned TABLE_DEPTH_DEF = 16;

    localparam int unsigned ADDR_W = 10;
    localparam int unsigned CNT_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // item kinds carried in the slave tuser
    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_ADD    = 1'b1
    } op_t;

    // result kinds carried in the master tuser
    typedef enum logic [2:0]
    {
        V_DROP    = 3'd0,
        V_ADMIT   = 3'd1,
        V_RELAY1  = 3'd2,
        V_RELAY2  = 3'd3,
        V_MISS    = 3'd4,
        V_BADPORT = 3'd5,
        V_ADDED   = 3'd6,
        V_FULL    = 3'd7
    } verdict_t;

    // rule actions and relay ports
    localparam logic       ACT_DROP    = 1'b0;
    localparam logic [1:0] PORT_RELAY1 = 2'd1;
    localparam logic [1:0] PORT_RELAY2 = 2'd2;

    // sequencer states
    typedef enum logic [1:0]
    {
        ST_IDLE   = 2'd0,
        ST_WALK   = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

    // one stored rule, 46 bits, source low in the lowest bits
    typedef struct packed
    {
        logic [2:0]        priority_lvl;
        logic [1:0]        port;
        logic              action;
        logic [ADDR_W-1:0] dst_high;
        logic [ADDR_W-1:0] dst_low;
        logic [ADDR_W-1:0] src_high;
        logic [ADDR_W-1:0] src_low;
    } rule_t;

    // lookup probe handed from cell to cell
    typedef struct packed
    {
        logic             found;
        logic             action;
        logic [1:0]       port;
        logic [CNT_W-1:0] hits;
    } probe_t;

    // saturating increment of a counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/range_flow_table_switch_core.sv -----
// ----------------------------------------------------------------------------
// range_flow_table_switch_core
// Flow table of destination range rules kept in a chain of rule cells, with
// hit counters and saturating admit and relay totals.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  --------  ---------  --------------------  -------------------------------
//  s_*       in         s_tvalid / s_tready   s_tuser kind, s_tdata item
//  m_*       out        m_tvalid / m_tready   m_tuser verdict, m_tdata result
//  apb       in         psel penable pwrite   own_ip_low @0, own_ip_high @4
//
//  A lookup walks the probe through the cell chain one cell a cycle, then the
//  winner is committed. An add goes straight to the commit step. One item is in
//  work at a time; the next transfer in is taken the cycle after the result is
//  loaded. The sequencer waits in its final step while the output register is
//  full and not taken. Reset clears the rule count, the totals, the own range
//  and the handshakes.
//
`default_nettype none

module range_flow_table_switch_core #(
    parameter int unsigned TABLE_DEPTH = rfts_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // item stream in
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // src_ip[9:0] dst_ip[19:10] rule_src_low[29:20] rule_src_high[39:30]
    // rule_dst_low[49:40] rule_dst_high[59:50] rule_action[60]
    // rule_port[62:61] rule_priority[65:63], zeros above
    input  wire logic [71:0]   s_tdata,
    // operation[0]
    input  wire logic [0:0]    s_tuser,
    // result stream out
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // rule_index[3:0] rule_hits[35:4] admit_total[67:36] relay_total[99:68]
    // relay_src[109:100] relay_dst[119:110]
    output logic [119:0]       m_tdata,
    // verdict[2:0]
    output logic [2:0]         m_tuser,
    // configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
    localparam int unsigned RC_W   = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned AW     = rfts_pkg::ADDR_W;
    localparam int unsigned CW     = rfts_pkg::CNT_W;
    localparam logic [RC_W-1:0]  DEPTH_COUNT = RC_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] WALK_LAST   = IDX_W'(TABLE_DEPTH - 1);

    // configuration registers
    logic [AW-1:0] own_lo_reg;
    logic [AW-1:0] own_hi_reg;
    logic          cfg_wr;

    // sequencer and item
    rfts_pkg::state_t  state_reg;
    rfts_pkg::state_t  state_next;
    logic [IDX_W-1:0]  walk_cnt_reg;
    rfts_pkg::op_t     op_reg;
    logic [AW-1:0]     src_reg;
    logic [AW-1:0]     dst_reg;
    rfts_pkg::rule_t   rule_in_reg;
    logic [RC_W-1:0]   rule_count_reg;
    logic [CW-1:0]     admit_reg;
    logic [CW-1:0]     relay_reg;

    // output register
    logic              m_tvalid_reg;
    logic [119:0]      m_tdata_reg;
    logic [2:0]        m_tuser_reg;

    logic              accept;
    logic              out_free;
    logic              fire;

    // commit decode
    logic                 wr_en;
    logic                 bump_en;
    logic [IDX_W-1:0]     sel_idx;
    rfts_pkg::verdict_t   verdict;
    logic [IDX_W-1:0]     idx_res;
    logic [CW-1:0]        hits_res;
    logic [CW-1:0]        admit_next;
    logic [CW-1:0]        relay_next;
    logic [RC_W-1:0]      rule_count_next;
    logic [AW-1:0]        rsrc;
    logic [AW-1:0]        rdst;

    // cell chain
    rfts_pkg::probe_t  probe [TABLE_DEPTH+1];
    logic [IDX_W-1:0]  pidx  [TABLE_DEPTH+1];

    // apb access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_lo_reg <= '0;
            own_hi_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                own_hi_reg <= pwdata[AW-1:0];
            end
            else
            begin
                own_lo_reg <= pwdata[AW-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = paddr[2] ? {(32-AW)'(0), own_hi_reg} : {(32-AW)'(0), own_lo_reg};
    end

    // handshakes
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rfts_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (rfts_pkg::op_t'(s_tuser[0]) == rfts_pkg::OP_ADD)
                               ? rfts_pkg::ST_FINISH : rfts_pkg::ST_WALK;
                end
            end
            rfts_pkg::ST_WALK:
            begin
                if (walk_cnt_reg == WALK_LAST)
                begin
                    state_next = rfts_pkg::ST_FINISH;
                end
            end
            rfts_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = rfts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfts_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        fire     = 1'b0;
        case (state_reg)
            rfts_pkg::ST_IDLE:   s_tready = 1'b1;
            rfts_pkg::ST_WALK:   s_tready = 1'b0;
            rfts_pkg::ST_FINISH: fire     = out_free;
            default:             s_tready = 1'b0;
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rfts_pkg::ST_IDLE;
            walk_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rfts_pkg::ST_WALK)
            begin
                walk_cnt_reg <= walk_cnt_reg + IDX_W'(1);
            end
            else
            begin
                walk_cnt_reg <= '0;
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= rfts_pkg::op_t'(s_tuser[0]);
            src_reg     <= s_tdata[9:0];
            dst_reg     <= s_tdata[19:10];
            rule_in_reg <= s_tdata[65:20];
        end
    end

    // commit decode for the finished item
    always_comb
    begin
        wr_en           = 1'b0;
        bump_en         = 1'b0;
        sel_idx         = '0;
        verdict         = rfts_pkg::V_MISS;
        idx_res         = '0;
        hits_res        = '0;
        admit_next      = admit_reg;
        relay_next      = relay_reg;
        rule_count_next = rule_count_reg;
        rsrc            = '0;
        rdst            = '0;
        case (op_reg)
            rfts_pkg::OP_ADD:
            begin
                if (rule_count_reg >= DEPTH_COUNT)
                begin
                    verdict = rfts_pkg::V_FULL;
                end
                else
                begin
                    verdict         = rfts_pkg::V_ADDED;
                    wr_en           = fire;
                    sel_idx         = rule_count_reg[IDX_W-1:0];
                    idx_res         = rule_count_reg[IDX_W-1:0];
                    rule_count_next = rule_count_reg + RC_W'(1);
                end
            end
            rfts_pkg::OP_LOOKUP:
            begin
                if (probe[TABLE_DEPTH].found)
                begin
                    bump_en  = fire;
                    sel_idx  = pidx[TABLE_DEPTH];
                    idx_res  = pidx[TABLE_DEPTH];
                    hits_res = rfts_pkg::sat_inc(probe[TABLE_DEPTH].hits);
                    if (probe[TABLE_DEPTH].action == rfts_pkg::ACT_DROP)
                    begin
                        verdict = rfts_pkg::V_DROP;
                    end
                    else if ((own_lo_reg <= dst_reg) && (own_hi_reg >= dst_reg))
                    begin
                        verdict    = rfts_pkg::V_ADMIT;
                        admit_next = rfts_pkg::sat_inc(admit_reg);
                    end
                    else if (probe[TABLE_DEPTH].port == rfts_pkg::PORT_RELAY1
                          || probe[TABLE_DEPTH].port == rfts_pkg::PORT_RELAY2)
                    begin
                        verdict    = (probe[TABLE_DEPTH].port == rfts_pkg::PORT_RELAY1)
                                   ? rfts_pkg::V_RELAY1 : rfts_pkg::V_RELAY2;
                        relay_next = rfts_pkg::sat_inc(relay_reg);
                        rsrc       = src_reg;
                        rdst       = dst_reg;
                    end
                    else
                    begin
                        verdict = rfts_pkg::V_BADPORT;
                    end
                end
            end
            default:
            begin
                verdict = rfts_pkg::V_MISS;
            end
        endcase
    end

    // table and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
            admit_reg      <= '0;
            relay_reg      <= '0;
        end
        else if (fire)
        begin
            rule_count_reg <= rule_count_next;
            admit_reg      <= admit_next;
            relay_reg      <= relay_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (fire)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_tdata_reg <= {rdst, rsrc, relay_next, admit_next, hits_res, 4'(idx_res)};
            m_tuser_reg <= verdict;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // chain of rule cells, probe enters empty at the head
    assign probe[0] = '0;
    assign pidx[0]  = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        rfts_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .CELL_IDX    (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .dst           (dst_reg),
            .rule_count    (rule_count_reg),
            .wr_en         (wr_en),
            .bump_en       (bump_en),
            .sel_idx       (sel_idx),
            .wr_rule       (rule_in_reg),
            .probe_in      (probe[i]),
            .probe_idx_in  (pidx[i]),
            .probe_out     (probe[i+1]),
            .probe_idx_out (pidx[i+1])
        );
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rule_count_reg <= DEPTH_COUNT)
        else $error("rule count beyond table depth");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> rule_count_reg == $past(rule_count_reg) + RC_W'(1))
        else $error("rule add did not grow the table");

    a_admit_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 admit_reg >= $past(admit_reg))
        else $error("admit total went down");

    a_relay_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && (m_tuser_reg == rfts_pkg::V_RELAY1
                      || m_tuser_reg == rfts_pkg::V_RELAY2)
        |-> m_tdata_reg[99:68] != '0)
        else $error("relay result with zero relay total");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != rfts_pkg::ST_IDLE)
        else $error("sequencer idle right after a transfer in");

endmodule

`default_nettype wire

// ----- rtl/rfts_cell.sv -----
// ----------------------------------------------------------------------------
// rfts_cell
// One rule cell: holds a rule and its hit counter, checks the passing probe
// against its destination range and hands the probe on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rfts_cell #(
    parameter int unsigned TABLE_DEPTH = rfts_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned CELL_IDX    = 0,
    localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH),
    localparam int unsigned RC_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // broadcast from the sequencer
    input  wire logic [rfts_pkg::ADDR_W-1:0]   dst,
    input  wire logic [RC_W-1:0]               rule_count,
    input  wire logic                          wr_en,
    input  wire logic                          bump_en,
    input  wire logic [IDX_W-1:0]              sel_idx,
    input  wire rfts_pkg::rule_t               wr_rule,
    // probe from the previous cell
    input  wire rfts_pkg::probe_t              probe_in,
    input  wire logic [IDX_W-1:0]              probe_idx_in,
    // probe to the next cell
    output rfts_pkg::probe_t                   probe_out,
    output logic [IDX_W-1:0]                   probe_idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
    localparam logic [RC_W-1:0]  MY_COUNT = RC_W'(CELL_IDX);

    rfts_pkg::rule_t                rule_reg;
    logic [rfts_pkg::CNT_W-1:0]     hits_reg;
    rfts_pkg::probe_t               probe_reg;
    rfts_pkg::probe_t               probe_next;
    logic [IDX_W-1:0]               pidx_reg;
    logic [IDX_W-1:0]               pidx_next;
    logic                           match;
    logic                           selected;

    // range check, only for a cell that holds a rule
    assign match = (rule_count > MY_COUNT)
                && (rule_reg.dst_low <= dst)
                && (rule_reg.dst_high >= dst);

    assign selected = (sel_idx == MY_IDX);

    // later match overrides the probe
    always_comb
    begin
        probe_next = probe_in;
        pidx_next  = probe_idx_in;
        if (match)
        begin
            probe_next.found  = 1'b1;
            probe_next.action = rule_reg.action;
            probe_next.port   = rule_reg.port;
            probe_next.hits   = hits_reg;
            pidx_next         = MY_IDX;
        end
    end

    // probe stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
            pidx_reg  <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            pidx_reg  <= pidx_next;
        end
    end

    // rule and hit counter storage
    always_ff @(posedge clk)
    begin
        if (wr_en && selected)
        begin
            rule_reg <= wr_rule;
            hits_reg <= '0;
        end
        else if (bump_en && selected)
        begin
            hits_reg <= rfts_pkg::sat_inc(hits_reg);
        end
    end

    assign probe_out     = probe_reg;
    assign probe_idx_out = pidx_reg;

endmodule

`default_nettype wire
